// File: hdl/assert_macros.svh
// assertion macros used by lalm_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// File: hdl/lalm_pkg.sv
`default_nettype none

package lalm_pkg;

    localparam int DEPTH      = 64;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int PTR_BITS   = ADDR_BITS + 1;
    localparam int VALUE_BITS = 16;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [PTR_BITS-1:0]   ptr_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    localparam ptr_t NIL = ptr_t'(DEPTH);

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_INS_HEAD  = 3'd1,
        OP_INS_TAIL  = 3'd2,
        OP_INS_AFTER = 3'd3,
        OP_DEL_AFTER = 3'd4,
        OP_FIND      = 3'd5,
        OP_FIRST     = 3'd6,
        OP_LAST      = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NO_SUCC   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FREE_RD,
        S_NODE_RD,
        S_VICTIM_RD,
        S_LINK_FIX,
        S_FIND_RD,
        S_PICK_RD,
        S_RESULT
    } state_t;

    typedef struct packed {
        op_t    op;
        addr_t  node_index;
        value_t item_value;
    } req_t;

    typedef struct packed {
        status_t status;
        ptr_t    result_index;
        value_t  result_value;
        logic    list_empty;
    } rsp_t;

    typedef struct packed {
        logic  clear;
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        ptr_t  wr_data;
    } link_req_t;

    typedef struct packed {
        logic   rd_en;
        addr_t  rd_addr;
        logic   wr_en;
        addr_t  wr_addr;
        value_t wr_data;
    } val_req_t;

endpackage

`default_nettype wire

// File: hdl/lalm_link_mem.sv
`default_nettype none

module lalm_link_mem (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lalm_pkg::link_req_t link_req,
    output lalm_pkg::ptr_t           link_rd
);

    lalm_pkg::ptr_t                 mem [lalm_pkg::DEPTH];
    logic [lalm_pkg::DEPTH-1:0]     written_reg;
    logic                           hit_reg;
    lalm_pkg::ptr_t                 mem_rd_reg;
    lalm_pkg::ptr_t                 alt_rd_reg;

    // an entry never written reads as the initial free chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (link_req.clear)
        begin
            written_reg <= '0;
        end
        else if (link_req.wr_en)
        begin
            written_reg[link_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_req.wr_en)
        begin
            mem[link_req.wr_addr] <= link_req.wr_data;
        end
        if (link_req.rd_en)
        begin
            mem_rd_reg <= mem[link_req.rd_addr];
            hit_reg    <= written_reg[link_req.rd_addr] && !link_req.clear
                          && !(link_req.wr_en && link_req.wr_addr == link_req.rd_addr);
            if (link_req.wr_en && link_req.wr_addr == link_req.rd_addr)
            begin
                alt_rd_reg <= link_req.wr_data;
            end
            else
            begin
                alt_rd_reg <= lalm_pkg::ptr_t'({1'b0, link_req.rd_addr})
                              + lalm_pkg::ptr_t'(1);
            end
        end
    end

    assign link_rd = hit_reg ? mem_rd_reg : alt_rd_reg;

endmodule

`default_nettype wire

// File: hdl/lalm_value_ram.sv
`default_nettype none

module lalm_value_ram (
    input  wire logic               clk,
    input  wire lalm_pkg::val_req_t val_req,
    output lalm_pkg::value_t        val_rd
);

    lalm_pkg::value_t mem [lalm_pkg::DEPTH];
    lalm_pkg::value_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (val_req.wr_en)
        begin
            mem[val_req.wr_addr] <= val_req.wr_data;
        end
        if (val_req.rd_en)
        begin
            rd_reg <= mem[val_req.rd_addr];
        end
    end

    assign val_rd = rd_reg;

endmodule

`default_nettype wire

// File: hdl/lalm_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module lalm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire lalm_pkg::req_t      req,
    output lalm_pkg::link_req_t      link_req,
    input  wire lalm_pkg::ptr_t      link_rd,
    output lalm_pkg::val_req_t       val_req,
    input  wire lalm_pkg::value_t    val_rd,
    output logic                     result_valid,
    input  wire logic                result_take,
    output lalm_pkg::rsp_t           result
);

    lalm_pkg::state_t           state_reg, state_next;
    lalm_pkg::op_t              op_reg, op_next;
    lalm_pkg::addr_t            node_reg, node_next;
    lalm_pkg::value_t           val_reg, val_next;
    lalm_pkg::ptr_t             head_reg, head_next;
    lalm_pkg::ptr_t             tail_reg, tail_next;
    lalm_pkg::ptr_t             free_reg, free_next;
    logic [lalm_pkg::DEPTH-1:0] in_list_reg, in_list_next;
    lalm_pkg::ptr_t             cur_reg, cur_next;
    lalm_pkg::addr_t            fix_addr_reg, fix_addr_next;
    lalm_pkg::ptr_t             fix_data_reg, fix_data_next;
    lalm_pkg::status_t          status_reg, status_next;
    lalm_pkg::ptr_t             idx_reg, idx_next;
    lalm_pkg::value_t           rval_reg, rval_next;

    logic free_nil;
    logic head_nil;
    logic tail_nil;
    logic node_ok;
    logic link_nil;
    logic find_hit;
    logic req_take;
    lalm_pkg::ptr_t node_ptr;

    assign free_nil  = (free_reg == lalm_pkg::NIL);
    assign head_nil  = (head_reg == lalm_pkg::NIL);
    assign tail_nil  = (tail_reg == lalm_pkg::NIL);
    assign node_ok   = in_list_reg[node_reg];
    assign link_nil  = (link_rd == lalm_pkg::NIL);
    assign find_hit  = (val_rd == val_reg);
    assign node_ptr  = lalm_pkg::ptr_t'({1'b0, node_reg});
    assign req_stall = (state_reg != lalm_pkg::S_IDLE);
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lalm_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lalm_pkg::S_DECODE;
                end
            end
            lalm_pkg::S_DECODE:
            begin
                case (op_reg)
                    lalm_pkg::OP_CLEAR:
                        state_next = lalm_pkg::S_RESULT;
                    lalm_pkg::OP_INS_HEAD, lalm_pkg::OP_INS_TAIL:
                        state_next = free_nil ? lalm_pkg::S_RESULT : lalm_pkg::S_FREE_RD;
                    lalm_pkg::OP_INS_AFTER:
                        state_next = (free_nil || !node_ok) ? lalm_pkg::S_RESULT
                                                            : lalm_pkg::S_FREE_RD;
                    lalm_pkg::OP_DEL_AFTER:
                        state_next = node_ok ? lalm_pkg::S_NODE_RD : lalm_pkg::S_RESULT;
                    lalm_pkg::OP_FIND:
                        state_next = head_nil ? lalm_pkg::S_RESULT : lalm_pkg::S_FIND_RD;
                    lalm_pkg::OP_FIRST:
                        state_next = head_nil ? lalm_pkg::S_RESULT : lalm_pkg::S_PICK_RD;
                    lalm_pkg::OP_LAST:
                        state_next = tail_nil ? lalm_pkg::S_RESULT : lalm_pkg::S_PICK_RD;
                    default:
                        state_next = lalm_pkg::S_RESULT;
                endcase
            end
            lalm_pkg::S_FREE_RD:
            begin
                case (op_reg)
                    lalm_pkg::OP_INS_TAIL:
                        state_next = head_nil ? lalm_pkg::S_RESULT : lalm_pkg::S_LINK_FIX;
                    lalm_pkg::OP_INS_AFTER:
                        state_next = lalm_pkg::S_NODE_RD;
                    default:
                        state_next = lalm_pkg::S_RESULT;
                endcase
            end
            lalm_pkg::S_NODE_RD:
            begin
                if (op_reg == lalm_pkg::OP_INS_AFTER)
                begin
                    state_next = lalm_pkg::S_LINK_FIX;
                end
                else if (link_nil)
                begin
                    state_next = lalm_pkg::S_RESULT;
                end
                else
                begin
                    state_next = lalm_pkg::S_VICTIM_RD;
                end
            end
            lalm_pkg::S_VICTIM_RD:
                state_next = lalm_pkg::S_LINK_FIX;
            lalm_pkg::S_LINK_FIX:
                state_next = lalm_pkg::S_RESULT;
            lalm_pkg::S_FIND_RD:
            begin
                if (find_hit || link_nil)
                begin
                    state_next = lalm_pkg::S_RESULT;
                end
            end
            lalm_pkg::S_PICK_RD:
                state_next = lalm_pkg::S_RESULT;
            lalm_pkg::S_RESULT:
            begin
                if (result_take)
                begin
                    state_next = lalm_pkg::S_IDLE;
                end
            end
            default:
                state_next = lalm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        node_next     = node_reg;
        val_next      = val_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = free_reg;
        in_list_next  = in_list_reg;
        cur_next      = cur_reg;
        fix_addr_next = fix_addr_reg;
        fix_data_next = fix_data_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;
        rval_next     = rval_reg;
        link_req      = '0;
        val_req       = '0;

        case (state_reg)
            lalm_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    op_next     = req.op;
                    node_next   = req.node_index;
                    val_next    = req.item_value;
                    status_next = lalm_pkg::ST_OK;
                    idx_next    = lalm_pkg::NIL;
                    rval_next   = '0;
                end
            end
            lalm_pkg::S_DECODE:
            begin
                case (op_reg)
                    lalm_pkg::OP_CLEAR:
                    begin
                        head_next      = lalm_pkg::NIL;
                        tail_next      = lalm_pkg::NIL;
                        free_next      = '0;
                        in_list_next   = '0;
                        link_req.clear = 1'b1;
                    end
                    lalm_pkg::OP_INS_HEAD, lalm_pkg::OP_INS_TAIL, lalm_pkg::OP_INS_AFTER:
                    begin
                        if (free_nil)
                        begin
                            status_next = lalm_pkg::ST_FULL;
                        end
                        else if (op_reg == lalm_pkg::OP_INS_AFTER && !node_ok)
                        begin
                            status_next = lalm_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            link_req.rd_en   = 1'b1;
                            link_req.rd_addr = free_reg[lalm_pkg::ADDR_BITS-1:0];
                        end
                    end
                    lalm_pkg::OP_DEL_AFTER:
                    begin
                        if (!node_ok)
                        begin
                            status_next = lalm_pkg::ST_NO_SUCC;
                        end
                        else
                        begin
                            link_req.rd_en   = 1'b1;
                            link_req.rd_addr = node_reg;
                        end
                    end
                    lalm_pkg::OP_FIND:
                    begin
                        if (head_nil)
                        begin
                            status_next = lalm_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            cur_next         = head_reg;
                            link_req.rd_en   = 1'b1;
                            link_req.rd_addr = head_reg[lalm_pkg::ADDR_BITS-1:0];
                            val_req.rd_en    = 1'b1;
                            val_req.rd_addr  = head_reg[lalm_pkg::ADDR_BITS-1:0];
                        end
                    end
                    lalm_pkg::OP_FIRST:
                    begin
                        if (head_nil)
                        begin
                            status_next = lalm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            idx_next        = head_reg;
                            val_req.rd_en   = 1'b1;
                            val_req.rd_addr = head_reg[lalm_pkg::ADDR_BITS-1:0];
                        end
                    end
                    lalm_pkg::OP_LAST:
                    begin
                        if (tail_nil)
                        begin
                            status_next = lalm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            idx_next        = tail_reg;
                            val_req.rd_en   = 1'b1;
                            val_req.rd_addr = tail_reg[lalm_pkg::ADDR_BITS-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            lalm_pkg::S_FREE_RD:
            begin
                // link_rd holds the next free node
                idx_next        = free_reg;
                free_next       = link_rd;
                val_req.wr_en   = 1'b1;
                val_req.wr_addr = free_reg[lalm_pkg::ADDR_BITS-1:0];
                val_req.wr_data = val_reg;
                in_list_next[free_reg[lalm_pkg::ADDR_BITS-1:0]] = 1'b1;
                case (op_reg)
                    lalm_pkg::OP_INS_HEAD:
                    begin
                        link_req.wr_en   = 1'b1;
                        link_req.wr_addr = free_reg[lalm_pkg::ADDR_BITS-1:0];
                        link_req.wr_data = head_reg;
                        head_next        = free_reg;
                        if (head_nil)
                        begin
                            tail_next = free_reg;
                        end
                    end
                    lalm_pkg::OP_INS_TAIL:
                    begin
                        link_req.wr_en   = 1'b1;
                        link_req.wr_addr = free_reg[lalm_pkg::ADDR_BITS-1:0];
                        link_req.wr_data = lalm_pkg::NIL;
                        tail_next        = free_reg;
                        fix_addr_next    = tail_reg[lalm_pkg::ADDR_BITS-1:0];
                        fix_data_next    = free_reg;
                        if (head_nil)
                        begin
                            head_next = free_reg;
                        end
                    end
                    default:
                    begin
                        link_req.rd_en   = 1'b1;
                        link_req.rd_addr = node_reg;
                    end
                endcase
            end
            lalm_pkg::S_NODE_RD:
            begin
                if (op_reg == lalm_pkg::OP_INS_AFTER)
                begin
                    link_req.wr_en   = 1'b1;
                    link_req.wr_addr = idx_reg[lalm_pkg::ADDR_BITS-1:0];
                    link_req.wr_data = link_rd;
                    fix_addr_next    = node_reg;
                    fix_data_next    = idx_reg;
                    if (tail_reg == node_ptr)
                    begin
                        tail_next = idx_reg;
                    end
                end
                else if (link_nil)
                begin
                    status_next = lalm_pkg::ST_NO_SUCC;
                end
                else
                begin
                    idx_next         = link_rd;
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = link_rd[lalm_pkg::ADDR_BITS-1:0];
                    val_req.rd_en    = 1'b1;
                    val_req.rd_addr  = link_rd[lalm_pkg::ADDR_BITS-1:0];
                end
            end
            lalm_pkg::S_VICTIM_RD:
            begin
                // unlink the victim and push it on the free list
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = node_reg;
                link_req.wr_data = link_rd;
                rval_next        = val_rd;
                fix_addr_next    = idx_reg[lalm_pkg::ADDR_BITS-1:0];
                fix_data_next    = free_reg;
                free_next        = idx_reg;
                in_list_next[idx_reg[lalm_pkg::ADDR_BITS-1:0]] = 1'b0;
                if (tail_reg == idx_reg)
                begin
                    tail_next = node_ptr;
                end
            end
            lalm_pkg::S_LINK_FIX:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = fix_addr_reg;
                link_req.wr_data = fix_data_reg;
            end
            lalm_pkg::S_FIND_RD:
            begin
                if (find_hit)
                begin
                    idx_next  = cur_reg;
                    rval_next = val_rd;
                end
                else if (link_nil)
                begin
                    status_next = lalm_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    cur_next         = link_rd;
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = link_rd[lalm_pkg::ADDR_BITS-1:0];
                    val_req.rd_en    = 1'b1;
                    val_req.rd_addr  = link_rd[lalm_pkg::ADDR_BITS-1:0];
                end
            end
            lalm_pkg::S_PICK_RD:
            begin
                rval_next = val_rd;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lalm_pkg::S_IDLE;
            head_reg    <= lalm_pkg::NIL;
            tail_reg    <= lalm_pkg::NIL;
            free_reg    <= '0;
            in_list_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            free_reg    <= free_next;
            in_list_reg <= in_list_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        node_reg     <= node_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        fix_addr_reg <= fix_addr_next;
        fix_data_reg <= fix_data_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
        rval_reg     <= rval_next;
    end

    assign result_valid        = (state_reg == lalm_pkg::S_RESULT);
    assign result.status       = status_reg;
    assign result.result_index = idx_reg;
    assign result.result_value = rval_reg;
    assign result.list_empty   = head_nil;

    `ASSERT_ALWAYS(a_head_tail_nil, clk, rst_n, head_nil == tail_nil)
    `ASSERT_ALWAYS(a_head_in_list, clk, rst_n, head_nil || in_list_reg[head_reg[lalm_pkg::ADDR_BITS-1:0]])
    `ASSERT_ALWAYS(a_tail_in_list, clk, rst_n, tail_nil || in_list_reg[tail_reg[lalm_pkg::ADDR_BITS-1:0]])
    `ASSERT_ALWAYS(a_free_not_listed, clk, rst_n, free_nil || !in_list_reg[free_reg[lalm_pkg::ADDR_BITS-1:0]])
    `ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_take, result_valid && $stable(result))

endmodule

`default_nettype wire

// File: hdl/array_linked_list_manager_top.sv
// from accepted transaction to result: clear and requests rejected at decode (store full,
// node not in the list, empty list) go straight to the result; insert head, first, last,
// insert tail into an empty list and delete after the tail pass a read state; other insert
// tail adds a link fix; insert after and delete after add a link fix too; find reads 1 to 64
// nodes. one transaction at a time; new requests stall until the result is taken.
// reset is asynchronous: list empty, free list 0..63, no link store clearing pass.
`default_nettype none

module array_linked_list_manager_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire lalm_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output lalm_pkg::rsp_t      rsp
);

    lalm_pkg::link_req_t link_req;
    lalm_pkg::ptr_t      link_rd;
    lalm_pkg::val_req_t  val_req;
    lalm_pkg::value_t    val_rd;
    logic                result_valid;
    logic                result_take;
    lalm_pkg::rsp_t      result;

    logic                rsp_valid_reg, rsp_valid_next;
    lalm_pkg::rsp_t      rsp_reg;

    lalm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .link_req     (link_req),
        .link_rd      (link_rd),
        .val_req      (val_req),
        .val_rd       (val_rd),
        .result_valid (result_valid),
        .result_take  (result_take),
        .result       (result)
    );

    lalm_link_mem u_link_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .link_req (link_req),
        .link_rd  (link_rd)
    );

    lalm_value_ram u_value_ram (
        .clk     (clk),
        .val_req (val_req),
        .val_rd  (val_rd)
    );

    // output register
    assign result_take = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (result_take)
        begin
            rsp_valid_next = result_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_take && result_valid)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: tb/array_linked_list_manager_top_tb.sv
`timescale 1ns / 100ps

module array_linked_list_manager_top_tb;

    localparam int MAX_CYCLES   = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_PRINTED  = 100;

    typedef struct {
        lalm_pkg::ptr_t   link [lalm_pkg::DEPTH];
        lalm_pkg::value_t vals [lalm_pkg::DEPTH];
        bit               member [lalm_pkg::DEPTH];
        lalm_pkg::ptr_t   head;
        lalm_pkg::ptr_t   tail;
        lalm_pkg::ptr_t   free_head;
    } list_state_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    lalm_pkg::req_t req       = '0;
    logic           rsp_stall = 1'b0;
    logic           req_stall;
    logic           rsp_valid;
    lalm_pkg::rsp_t rsp;

    lalm_pkg::req_t request_queue[$];
    lalm_pkg::rsp_t awaited_results[$];
    lalm_pkg::rsp_t want;
    list_state_t    model_list;
    list_state_t    plan_list;
    int             send_idle_pct;
    int             stall_pct;
    bit             growing;
    int             errors;
    int             cycles;

    array_linked_list_manager_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic void empty_list(inout list_state_t s);
        for (int i = 0; i < lalm_pkg::DEPTH; i++)
        begin
            s.link[i]   = lalm_pkg::ptr_t'(i + 1);
            s.member[i] = 1'b0;
        end
        s.head      = lalm_pkg::NIL;
        s.tail      = lalm_pkg::NIL;
        s.free_head = '0;
    endfunction

    function automatic lalm_pkg::rsp_t apply_request(inout list_state_t s,
                                                     input lalm_pkg::req_t r);
        lalm_pkg::rsp_t  o;
        lalm_pkg::ptr_t  slot;
        lalm_pkg::ptr_t  cur;
        int              steps;
        bit              node_ok;
        lalm_pkg::addr_t n;
        n = r.node_index;
        node_ok = s.member[n];
        o.status       = lalm_pkg::ST_OK;
        o.result_index = lalm_pkg::NIL;
        o.result_value = '0;
        case (r.op)
            lalm_pkg::OP_CLEAR:
                empty_list(s);
            lalm_pkg::OP_INS_HEAD, lalm_pkg::OP_INS_TAIL, lalm_pkg::OP_INS_AFTER:
            begin
                if (s.free_head == lalm_pkg::NIL)
                    o.status = lalm_pkg::ST_FULL;
                else if (r.op == lalm_pkg::OP_INS_AFTER && !node_ok)
                    o.status = lalm_pkg::ST_NOT_FOUND;
                else
                begin
                    slot = s.free_head;
                    s.free_head = s.link[slot];
                    s.vals[slot] = r.item_value;
                    s.member[slot] = 1'b1;
                    o.result_index = slot;
                    if (r.op == lalm_pkg::OP_INS_HEAD)
                    begin
                        s.link[slot] = s.head;
                        if (s.head == lalm_pkg::NIL)
                            s.tail = slot;
                        s.head = slot;
                    end
                    else if (r.op == lalm_pkg::OP_INS_TAIL)
                    begin
                        s.link[slot] = lalm_pkg::NIL;
                        if (s.head == lalm_pkg::NIL)
                            s.head = slot;
                        else
                            s.link[s.tail] = slot;
                        s.tail = slot;
                    end
                    else
                    begin
                        s.link[slot] = s.link[n];
                        s.link[n] = slot;
                        if (s.tail == lalm_pkg::ptr_t'(n))
                            s.tail = slot;
                    end
                end
            end
            lalm_pkg::OP_DEL_AFTER:
            begin
                if (!node_ok || s.link[n] == lalm_pkg::NIL)
                    o.status = lalm_pkg::ST_NO_SUCC;
                else
                begin
                    cur = s.link[n];
                    s.link[n] = s.link[cur];
                    if (s.tail == cur)
                        s.tail = lalm_pkg::ptr_t'(n);
                    s.link[cur] = s.free_head;
                    s.free_head = cur;
                    s.member[cur] = 1'b0;
                    o.result_index = cur;
                    o.result_value = s.vals[cur];
                end
            end
            lalm_pkg::OP_FIND:
            begin
                cur = s.head;
                steps = 0;
                while (cur != lalm_pkg::NIL && steps < lalm_pkg::DEPTH
                       && s.vals[cur] != r.item_value)
                begin
                    cur = s.link[cur];
                    steps++;
                end
                if (cur != lalm_pkg::NIL && steps < lalm_pkg::DEPTH)
                begin
                    o.result_index = cur;
                    o.result_value = s.vals[cur];
                end
                else
                    o.status = lalm_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                cur = (r.op == lalm_pkg::OP_FIRST) ? s.head : s.tail;
                if (cur == lalm_pkg::NIL)
                    o.status = lalm_pkg::ST_EMPTY;
                else
                begin
                    o.result_index = cur;
                    o.result_value = s.vals[cur];
                end
            end
        endcase
        o.list_empty = (s.head == lalm_pkg::NIL);
        return o;
    endfunction

    task automatic queue_request(input lalm_pkg::op_t op, input int unsigned node,
                                 input lalm_pkg::value_t v);
        lalm_pkg::req_t r;
        r.op         = op;
        r.node_index = lalm_pkg::addr_t'(node);
        r.item_value = v;
        void'(apply_request(plan_list, r));
        request_queue.push_back(r);
    endtask

    // mostly well-formed list traffic: grow to full, then shrink or clear
    function automatic lalm_pkg::req_t pick_request();
        lalm_pkg::req_t  r;
        lalm_pkg::addr_t members[$];
        int              roll;
        for (int i = 0; i < lalm_pkg::DEPTH; i++)
            if (plan_list.member[i])
                members.push_back(lalm_pkg::addr_t'(i));
        if (members.size() == lalm_pkg::DEPTH)
            growing = 1'b0;
        else if (members.size() == 0)
            growing = 1'b1;
        roll = $urandom_range(99);
        r.item_value = ($urandom_range(2) == 0) ? lalm_pkg::value_t'($urandom_range(7))
                                                : lalm_pkg::value_t'($urandom);
        if (members.size() > 0 && $urandom_range(9) < 8)
            r.node_index = members[$urandom_range(members.size() - 1)];
        else
            r.node_index = lalm_pkg::addr_t'($urandom_range(lalm_pkg::DEPTH - 1));
        if (members.size() == lalm_pkg::DEPTH && roll < 50)
        begin
            case ($urandom_range(2))
                0:       r.op = lalm_pkg::OP_INS_HEAD;
                1:       r.op = lalm_pkg::OP_INS_TAIL;
                default: r.op = lalm_pkg::OP_INS_AFTER;
            endcase
        end
        else if (growing)
        begin
            if (roll < 22)      r.op = lalm_pkg::OP_INS_HEAD;
            else if (roll < 44) r.op = lalm_pkg::OP_INS_TAIL;
            else if (roll < 62) r.op = lalm_pkg::OP_INS_AFTER;
            else if (roll < 72) r.op = lalm_pkg::OP_DEL_AFTER;
            else if (roll < 86) r.op = lalm_pkg::OP_FIND;
            else if (roll < 93) r.op = lalm_pkg::OP_FIRST;
            else                r.op = lalm_pkg::OP_LAST;
        end
        else
        begin
            if (roll < 4)       r.op = lalm_pkg::OP_CLEAR;
            else if (roll < 12) r.op = lalm_pkg::OP_INS_HEAD;
            else if (roll < 18) r.op = lalm_pkg::OP_INS_TAIL;
            else if (roll < 24) r.op = lalm_pkg::OP_INS_AFTER;
            else if (roll < 68) r.op = lalm_pkg::OP_DEL_AFTER;
            else if (roll < 84) r.op = lalm_pkg::OP_FIND;
            else if (roll < 92) r.op = lalm_pkg::OP_FIRST;
            else                r.op = lalm_pkg::OP_LAST;
        end
        if (r.op == lalm_pkg::OP_FIND && members.size() > 0 && $urandom_range(9) < 7)
            r.item_value = plan_list.vals[members[$urandom_range(members.size() - 1)]];
        return r;
    endfunction

    task automatic add_random(input int count);
        lalm_pkg::req_t r;
        for (int i = 0; i < count; i++)
        begin
            r = pick_request();
            void'(apply_request(plan_list, r));
            request_queue.push_back(r);
        end
    endtask

    task automatic wait_drained();
        while (request_queue.size() != 0 || req_valid || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_error(input string msg);
        if (errors < MAX_PRINTED)
            $display("error: %s", msg);
        errors++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                awaited_results.push_back(apply_request(model_list, req));
            if (!(req_valid && req_stall))
            begin
                if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req       <= request_queue.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                    note_error("result transaction with none expected");
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.status !== want.status)
                        note_error($sformatf("status got %0d expected %0d",
                                             rsp.status, want.status));
                    if (rsp.result_index !== want.result_index)
                        note_error($sformatf("result_index got %0d expected %0d",
                                             rsp.result_index, want.result_index));
                    if (rsp.result_value !== want.result_value)
                        note_error($sformatf("result_value got %h expected %h",
                                             rsp.result_value, want.result_value));
                    if (rsp.list_empty !== want.list_empty)
                        note_error($sformatf("list_empty got %b expected %b",
                                             rsp.list_empty, want.list_empty));
                end
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= MAX_CYCLES)
        begin
            $display("** array_linked_list_manager_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        empty_list(model_list);
        empty_list(plan_list);
        errors        = 0;
        cycles        = 0;
        growing       = 1'b1;
        send_idle_pct = 8;
        stall_pct     = 66;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list and free node corner cases
        queue_request(lalm_pkg::OP_FIRST, 0, 16'h0000);
        queue_request(lalm_pkg::OP_LAST, 63, 16'hffff);
        queue_request(lalm_pkg::OP_FIND, 0, 16'h0000);
        queue_request(lalm_pkg::OP_DEL_AFTER, 0, 16'h0000);
        queue_request(lalm_pkg::OP_INS_AFTER, 63, 16'hffff);
        // build, walk and trim a short list
        queue_request(lalm_pkg::OP_INS_HEAD, 0, 16'h0000);
        queue_request(lalm_pkg::OP_INS_TAIL, 63, 16'hffff);
        queue_request(lalm_pkg::OP_INS_AFTER, 0, 16'h8000);
        queue_request(lalm_pkg::OP_INS_AFTER, 1, 16'h1234);
        queue_request(lalm_pkg::OP_LAST, 0, 16'h0000);
        queue_request(lalm_pkg::OP_FIRST, 0, 16'h0000);
        queue_request(lalm_pkg::OP_FIND, 0, 16'hffff);
        queue_request(lalm_pkg::OP_FIND, 0, 16'h5555);
        queue_request(lalm_pkg::OP_DEL_AFTER, 3, 16'h0000);
        queue_request(lalm_pkg::OP_DEL_AFTER, 1, 16'h0000);
        queue_request(lalm_pkg::OP_LAST, 0, 16'h0000);
        queue_request(lalm_pkg::OP_DEL_AFTER, 0, 16'h0000);
        queue_request(lalm_pkg::OP_INS_HEAD, 0, 16'haaaa);
        queue_request(lalm_pkg::OP_CLEAR, 63, 16'hffff);
        queue_request(lalm_pkg::OP_FIRST, 0, 16'h0000);
        queue_request(lalm_pkg::OP_INS_TAIL, 0, 16'h0001);
        queue_request(lalm_pkg::OP_DEL_AFTER, 0, 16'h0000);
        queue_request(lalm_pkg::OP_FIND, 0, 16'h0001);
        queue_request(lalm_pkg::OP_CLEAR, 0, 16'h0000);

        add_random(110);
        wait_drained();
        add_random(110);
        wait_drained();

        send_idle_pct = 66;
        stall_pct     = 8;
        add_random(215);
        wait_drained();

        send_idle_pct = 0;
        stall_pct     = 0;
        add_random(215);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** array_linked_list_manager_top: PASSED **");
        else
            $display("** array_linked_list_manager_top: FAILED **");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/lalm_pkg.sv
hdl/lalm_link_mem.sv
hdl/lalm_value_ram.sv
hdl/lalm_ctrl.sv
hdl/array_linked_list_manager_top.sv
tb/array_linked_list_manager_top_tb.sv
